>>> design/hang_agc_iq_assert.svh
// Assertion macros for the hang AGC block.
`ifndef HANG_AGC_IQ_ASSERT_SVH
`define HANG_AGC_IQ_ASSERT_SVH
`ifndef ASSERT_OFF
`define HAI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HAI_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HAI_ASSERT(label, prop, msg)
`define HAI_ASSERT_RST(label, prop, msg)
`endif
`endif

>>> design/hai_pkg.sv
// Shared types and constants for the hang AGC block.
package hai_pkg;
  localparam logic [31:0] GAIN_RESET = 32'd655360;
  localparam logic [14:0] HEADROOM_RESET = 15'd16384;
  localparam logic [16:0] RECOVERY_RESET = 17'd65540;
  localparam logic [15:0] HANG_RESET = 16'd52800;
  localparam logic [1:0] REG_HEADROOM = 2'd0;
  localparam logic [1:0] REG_RECOVERY = 2'd1;
  localparam logic [1:0] REG_HANG = 2'd2;
  localparam int QDEPTH = 2;

  // Front-to-back queue entry: sample and magnitude.
  typedef struct packed {
    logic signed [15:0] si;
    logic signed [15:0] sq;
    logic [15:0] mag;
  } hai_item_t;
endpackage

>>> design/hang_agc_iq.sv
// Hang AGC for complex baseband: one I/Q sample in, one scaled sample out.
// The front end takes a sample, finds its magnitude with a bit-serial square root
// and passes it through a two-entry queue to the gain unit. The gain
// unit compares magnitude times gain with the headroom; on overload it divides
// headroom by magnitude one quotient bit a cycle and reloads the hang
// counter, otherwise it counts hang down or applies the recovery factor, then
// scales I and Q in turn. Neither the front end nor the gain unit takes a new
// sample before its last one has been passed on, and the output stall holds the
// gain unit; the slower of the two sets the sustained rate. Configuration is
// written through cfg_we, cfg_idx, cfg_data (0 headroom, 1 recovery Q1.16,
// 2 hang length) while the block is idle; the block does not enforce this.
module hang_agc_iq import hai_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [16:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] in_i,
  input  logic signed [15:0] in_q,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [15:0] out_i,
  output logic signed [15:0] out_q,
  output logic [31:0] gain_now,
  output logic overload
);
  logic f_valid, f_stall, b_valid, b_stall;
  hai_item_t f_item, b_item;

  hai_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_i, .in_q,
    .q_valid(f_valid), .q_stall(f_stall), .q_item(f_item)
  );

  hai_queue u_queue (
    .clk, .rst, .wvalid(f_valid), .wstall(f_stall), .wdata(f_item),
    .rvalid(b_valid), .rstall(b_stall), .rdata(b_item)
  );

  hai_back u_back (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .q_valid(b_valid), .q_stall(b_stall), .q_item(b_item),
    .out_valid, .out_stall, .out_i, .out_q, .gain_now, .overload
  );
endmodule

>>> design/hai_front.sv
// Front end: accept a sample and find its magnitude with a bit-serial square root.
module hai_front import hai_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] in_i,
  input  logic signed [15:0] in_q,
  output logic q_valid,
  input  logic q_stall,
  output hai_item_t q_item
);
  typedef enum logic [2:0] {
    F_IDLE = 3'b001, F_SQRT = 3'b010, F_DONE = 3'b100
  } fstate_t;

  fstate_t state;
  logic signed [15:0] si, sq;
  logic [31:0] rem;
  logic [31:0] res;
  logic [4:0] step;
  logic [15:0] ai, aq;
  logic [32:0] trial;

  assign in_stall = (state != F_IDLE);
  assign ai = in_i[15] ? 16'(-in_i) : in_i;
  assign aq = in_q[15] ? 16'(-in_q) : in_q;
  assign trial = {1'b0, res} + (33'd1 << {step, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            si <= in_i;
            sq <= in_q;
            rem <= (32'(ai) * 32'(ai)) + (32'(aq) * 32'(aq));
            res <= '0;
            step <= 5'd15;
            state <= F_SQRT;
          end
        end
        F_SQRT: begin
          // one result bit a cycle, bit weight 4^step
          if ({1'b0, rem} >= trial) begin
            rem <= rem - trial[31:0];
            res <= (res >> 1) + (32'd1 << {step, 1'b0});
          end else begin
            res <= res >> 1;
          end
          if (step == 5'd0) state <= F_DONE;
          else step <= step - 5'd1;
        end
        F_DONE: begin
          if (!q_stall) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign q_valid = (state == F_DONE);
  assign q_item = '{si: si, sq: sq, mag: res[15:0]};
endmodule

>>> design/hai_queue.sv
// Short queue between the front end and the gain unit.
module hai_queue import hai_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wvalid,
  output logic wstall,
  input  hai_item_t wdata,
  output logic rvalid,
  input  logic rstall,
  output hai_item_t rdata
);
  hai_item_t mem [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp, rp;
  logic [$clog2(QDEPTH):0] cnt;
  logic push, pop;

  assign wstall = (cnt == ($clog2(QDEPTH)+1)'(QDEPTH));
  assign rvalid = (cnt != '0);
  assign push = wvalid && !wstall;
  assign pop = rvalid && !rstall;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (($clog2(QDEPTH)+1)'(push)) - (($clog2(QDEPTH)+1)'(pop));
    end
  end

  `include "hang_agc_iq_assert.svh"
  `HAI_ASSERT(a_no_overflow, cnt <= ($clog2(QDEPTH)+1)'(QDEPTH), "queue count overflow")
  `HAI_ASSERT(a_pop_needs_data, pop |-> cnt != '0, "pop from empty queue")
  `HAI_ASSERT(a_cnt_track, (push && !pop) |=> cnt == $past(cnt) + 1'b1, "count slip")
endmodule

>>> design/hai_back.sv
// Back end: gain update (compare, divide or recover), scaling and output register.
module hai_back import hai_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [16:0] cfg_data,
  input  logic q_valid,
  output logic q_stall,
  input  hai_item_t q_item,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [15:0] out_i,
  output logic signed [15:0] out_q,
  output logic [31:0] gain_now,
  output logic overload
);
  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001, B_TEST = 7'b0000010, B_DIV = 7'b0000100,
    B_REC = 7'b0001000, B_SCI = 7'b0010000, B_SCQ = 7'b0100000,
    B_OUT = 7'b1000000
  } bstate_t;

  bstate_t state;
  logic [14:0] headroom;
  logic [16:0] recovery;
  logic [15:0] hang_samples;
  logic [31:0] gain;
  logic [15:0] hang_count;
  hai_item_t item;
  logic ovl;
  logic ovl_hit;
  logic [47:0] prod;
  logic [31:0] quo;
  logic [16:0] drem;
  logic [30:0] dnum;
  logic [4:0] dcnt;
  logic [16:0] dtry;
  logic [48:0] rprod;
  logic [15:0] sa;
  logic [47:0] sprod;
  logic [32:0] mq;
  logic [15:0] sat_val;
  logic sneg;

  assign q_stall = (state != B_IDLE);
  assign ovl_hit = (prod > {17'd0, headroom, 16'd0});

  // long division headroom*2^16 / mag, one bit a cycle (31 bits of numerator)
  assign dtry = {drem[15:0], dnum[30]};

  assign sneg = (state == B_SCI) ? item.si[15] : item.sq[15];
  always_comb begin
    if (state == B_SCI) sa = item.si[15] ? 16'(-item.si) : item.si;
    else sa = item.sq[15] ? 16'(-item.sq) : item.sq;
  end
  assign sprod = 48'(sa) * 48'(gain);
  assign mq = 33'((sprod + 48'd32768) >> 16);
  always_comb begin
    if (sneg) sat_val = (mq > 33'd32768) ? 16'h8000 : 16'(-mq[15:0]);
    else sat_val = (mq > 33'd32767) ? 16'h7FFF : mq[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      headroom <= HEADROOM_RESET;
      recovery <= RECOVERY_RESET;
      hang_samples <= HANG_RESET;
      gain <= GAIN_RESET;
      hang_count <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_HEADROOM: headroom <= cfg_data[14:0];
          REG_RECOVERY: recovery <= cfg_data;
          REG_HANG: hang_samples <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            item <= q_item;
            prod <= 48'(q_item.mag) * 48'(gain);
            state <= B_TEST;
          end
        end
        B_TEST: begin
          ovl <= ovl_hit;
          if (ovl_hit) begin
            hang_count <= hang_samples;
            dnum <= {headroom, 16'd0};
            drem <= '0;
            quo <= '0;
            dcnt <= 5'd30;
            state <= B_DIV;
          end else if (hang_count != '0) begin
            hang_count <= hang_count - 16'd1;
            state <= B_SCI;
          end else begin
            rprod <= 49'(gain) * 49'(recovery);
            state <= B_REC;
          end
        end
        B_DIV: begin
          if (dtry >= {1'b0, item.mag}) begin
            drem <= dtry - {1'b0, item.mag};
            quo <= {quo[30:0], 1'b1};
          end else begin
            drem <= dtry;
            quo <= {quo[30:0], 1'b0};
          end
          dnum <= {dnum[29:0], 1'b0};
          if (dcnt == 5'd0) state <= B_REC;
          else dcnt <= dcnt - 5'd1;
        end
        B_REC: begin
          if (ovl) gain <= quo;
          else if (((rprod + 49'd32768) >> 16) > 49'hFFFFFFFF) gain <= 32'hFFFFFFFF;
          else gain <= 32'((rprod + 49'd32768) >> 16);
          state <= B_SCI;
        end
        B_SCI: begin
          out_i <= sat_val;
          state <= B_SCQ;
        end
        B_SCQ: begin
          out_q <= sat_val;
          gain_now <= gain;
          overload <= ovl;
          state <= B_OUT;
        end
        B_OUT: begin
          if (!out_stall) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign out_valid = (state == B_OUT);

  `include "hang_agc_iq_assert.svh"
  `HAI_ASSERT(a_ovl_reload, (state == B_TEST && ovl_hit) |=> hang_count == hang_samples, "hang not reloaded")
  `HAI_ASSERT(a_out_gain, out_valid |-> gain_now == gain, "output gain differs from kept gain")
  `HAI_ASSERT(a_out_hold, (out_valid && out_stall) |=> out_valid, "result dropped while stalled")
  `HAI_ASSERT_RST(a_reset_idle, rst |=> state == B_IDLE, "not idle after reset")
endmodule
